// File: rtl/core/keyed_setting_table_assert.svh
// Assertion macros for the keyed setting table.
// Included by files that check their own logic; needs nothing else.
`ifndef KEYED_SETTING_TABLE_ASSERT_SVH
`define KEYED_SETTING_TABLE_ASSERT_SVH

// same-cycle implication
`define KST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/kst_pkg.sv
// Shared types and codes for the keyed setting table.
// Used by kst_cell and keyed_setting_table; depends on nothing.
package kst_pkg;

	localparam int unsigned HASH_BITS    = 16;
	localparam int unsigned KIND_BITS    = 3;
	localparam int unsigned STATUS_BITS  = 3;
	localparam int unsigned INDEX_BITS   = 5;
	localparam int unsigned COUNT_BITS   = 6;
	localparam int unsigned IN_PAY_BITS  = 32;
	localparam int unsigned OUT_PAY_BITS = 32;

	localparam logic [KIND_BITS-1:0] KIND_CLEAR   = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_POP     = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_INSERT  = 3'd2;
	localparam logic [KIND_BITS-1:0] KIND_LOOKUP  = 3'd3;
	localparam logic [KIND_BITS-1:0] KIND_COLLECT = 3'd4;

	localparam logic [STATUS_BITS-1:0] ST_REPLACED  = 3'd0;
	localparam logic [STATUS_BITS-1:0] ST_APPENDED  = 3'd1;
	localparam logic [STATUS_BITS-1:0] ST_OVERFLOW  = 3'd2;
	localparam logic [STATUS_BITS-1:0] ST_FOUND     = 3'd3;
	localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd4;
	localparam logic [STATUS_BITS-1:0] ST_COLL_ITEM = 3'd5;
	localparam logic [STATUS_BITS-1:0] ST_COLL_END  = 3'd6;
	localparam logic [STATUS_BITS-1:0] ST_DONE      = 3'd7;

	typedef struct packed {
		logic [HASH_BITS-1:0] group;
		logic [HASH_BITS-1:0] member;
		logic [HASH_BITS-1:0] name;
	} key_t;

	// control broadcast to every cell
	typedef struct packed {
		logic load;      // capture the compare result into the pending bit
		logic full_key;  // compare all three hashes, else group and name only
		logic consume;   // drop the pending bit of the first pending cell
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_RESOLVE
	} state_t;

endpackage

// File: rtl/core/keyed_setting_table.sv
// Keyed setting table: a row of entry cells with a first-match chain.
// A request passes the match and resolve states; results are registered before output.
// A new request is taken only while idle; collect returns each match, then an end marker,
// one result per cycle, set by the single scan of the cell chain per cycle.
// Reset clears the entry count and the overflow flag; stored entries stay undefined.
// Results are shown for one cycle with result_valid; the receiver cannot stall.
module keyed_setting_table #(
	parameter int unsigned TABLE_DEPTH  = 32,
	parameter int unsigned PAYLOAD_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [kst_pkg::KIND_BITS-1:0]    kind,
	input  logic [kst_pkg::HASH_BITS-1:0]    key_group,
	input  logic [kst_pkg::HASH_BITS-1:0]    key_member,
	input  logic [kst_pkg::HASH_BITS-1:0]    key_name,
	input  logic [kst_pkg::IN_PAY_BITS-1:0]  entry_payload,
	output logic                             result_valid,
	output logic [kst_pkg::STATUS_BITS-1:0]  status,
	output logic [kst_pkg::INDEX_BITS-1:0]   entry_index,
	output logic [kst_pkg::OUT_PAY_BITS-1:0] found_payload,
	output logic [kst_pkg::HASH_BITS-1:0]    found_member_key,
	output logic [kst_pkg::COUNT_BITS-1:0]   entries_used,
	output logic                             load_error,
	output logic                             last
);

	`include "keyed_setting_table_assert.svh"

	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

	kst_pkg::state_t state_q, state_d;

	logic [kst_pkg::KIND_BITS-1:0] kind_q;
	kst_pkg::key_t                 key_q;
	logic [PAYLOAD_BITS-1:0]       pay_q;
	logic [CNT_W-1:0]              count_q, count_d;
	logic                          err_q, err_d;

	kst_pkg::cell_ctrl_t     ctrl;
	logic [TABLE_DEPTH-1:0]  valid_vec;
	logic [TABLE_DEPTH-1:0]  first_vec;
	logic [TABLE_DEPTH:0]    hit_chain;
	logic [TABLE_DEPTH-1:0]  wr_key_vec;
	logic [TABLE_DEPTH-1:0]  wr_pay_vec;
	logic [kst_pkg::HASH_BITS-1:0] cell_member [TABLE_DEPTH];
	logic [PAYLOAD_BITS-1:0]       cell_pay    [TABLE_DEPTH];

	logic [IDX_W-1:0]              sel_idx;
	logic [PAYLOAD_BITS-1:0]       sel_pay;
	logic [kst_pkg::HASH_BITS-1:0] sel_member;
	logic                          any_hit;

	logic                            emit;
	logic [kst_pkg::STATUS_BITS-1:0] res_status;
	logic [IDX_W-1:0]                res_idx;
	logic [PAYLOAD_BITS-1:0]         res_pay;
	logic [kst_pkg::HASH_BITS-1:0]   res_member;
	logic                            res_last;
	logic                            do_replace;
	logic                            do_append;

	logic                              res_valid_q;
	logic [kst_pkg::STATUS_BITS-1:0]   res_status_q;
	logic [kst_pkg::INDEX_BITS-1:0]    res_idx_q;
	logic [kst_pkg::OUT_PAY_BITS-1:0]  res_pay_q;
	logic [kst_pkg::HASH_BITS-1:0]     res_member_q;
	logic [kst_pkg::COUNT_BITS-1:0]    res_used_q;
	logic                              res_err_q;
	logic                              res_last_q;

	assign busy = (state_q != kst_pkg::S_IDLE);

	// request capture
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_q <= kind;
			key_q  <= '{group: key_group, member: key_member, name: key_name};
			pay_q  <= PAYLOAD_BITS'(entry_payload);
		end
	end

	// cell row
	assign hit_chain[0] = 1'b0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		assign valid_vec[i] = (CNT_W'(i) < count_q);
		kst_cell #(
			.PAYLOAD_BITS (PAYLOAD_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.valid   (valid_vec[i]),
			.cmp_key (key_q),
			.wr_key  (wr_key_vec[i]),
			.wr_pay  (wr_pay_vec[i]),
			.wr_data (pay_q),
			.hit_in  (hit_chain[i]),
			.hit_out (hit_chain[i+1]),
			.first   (first_vec[i]),
			.member  (cell_member[i]),
			.payload (cell_pay[i])
		);
	end

	assign any_hit = hit_chain[TABLE_DEPTH];

	// first_vec is one-hot or empty: encode index and select fields by AND-OR
	always_comb begin
		sel_idx    = '0;
		sel_pay    = '0;
		sel_member = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (first_vec[i]) begin
				sel_idx    = sel_idx | IDX_W'(i);
				sel_pay    = sel_pay | cell_pay[i];
				sel_member = sel_member | cell_member[i];
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kst_pkg::S_IDLE: begin
				if (start) begin
					state_d = kst_pkg::S_MATCH;
				end
			end
			kst_pkg::S_MATCH: begin
				state_d = kst_pkg::S_RESOLVE;
			end
			kst_pkg::S_RESOLVE: begin
				if (!(kind_q == kst_pkg::KIND_COLLECT && any_hit)) begin
					state_d = kst_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = kst_pkg::S_IDLE;
			end
		endcase
	end

	// outputs and table updates
	always_comb begin
		ctrl.load     = (state_q == kst_pkg::S_MATCH);
		ctrl.full_key = (kind_q != kst_pkg::KIND_COLLECT);
		ctrl.consume  = 1'b0;
		emit       = 1'b0;
		res_status = kst_pkg::ST_DONE;
		res_idx    = '0;
		res_pay    = '0;
		res_member = '0;
		res_last   = 1'b1;
		do_replace = 1'b0;
		do_append  = 1'b0;
		count_d    = count_q;
		err_d      = err_q;
		if (state_q == kst_pkg::S_RESOLVE) begin
			emit = 1'b1;
			case (kind_q)
				kst_pkg::KIND_CLEAR: begin
					count_d = '0;
				end
				kst_pkg::KIND_POP: begin
					if (count_q != '0) begin
						count_d = count_q - 1'b1;
						res_idx = IDX_W'(count_q - 1'b1);
					end
				end
				kst_pkg::KIND_INSERT: begin
					if (any_hit) begin
						do_replace = 1'b1;
						res_status = kst_pkg::ST_REPLACED;
						res_idx    = sel_idx;
					end else if (count_q < CNT_W'(TABLE_DEPTH)) begin
						do_append  = 1'b1;
						res_status = kst_pkg::ST_APPENDED;
						res_idx    = IDX_W'(count_q);
						count_d    = count_q + 1'b1;
					end else begin
						res_status = kst_pkg::ST_OVERFLOW;
						err_d      = 1'b1;
					end
				end
				kst_pkg::KIND_LOOKUP: begin
					if (any_hit) begin
						res_status = kst_pkg::ST_FOUND;
						res_idx    = sel_idx;
						res_pay    = sel_pay;
					end else begin
						res_status = kst_pkg::ST_NOT_FOUND;
					end
				end
				kst_pkg::KIND_COLLECT: begin
					if (any_hit) begin
						ctrl.consume = 1'b1;
						res_status   = kst_pkg::ST_COLL_ITEM;
						res_idx      = sel_idx;
						res_member   = sel_member;
						res_last     = 1'b0;
					end else begin
						res_status = kst_pkg::ST_COLL_END;
					end
				end
				default: begin
					res_status = kst_pkg::ST_DONE;
				end
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			wr_key_vec[i] = do_append && (CNT_W'(i) == count_q);
			wr_pay_vec[i] = wr_key_vec[i] || (do_replace && first_vec[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kst_pkg::S_IDLE;
			count_q     <= '0;
			err_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			err_q       <= err_d;
			res_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_status_q <= res_status;
			res_idx_q    <= kst_pkg::INDEX_BITS'(res_idx);
			res_pay_q    <= kst_pkg::OUT_PAY_BITS'(res_pay);
			res_member_q <= res_member;
			res_used_q   <= kst_pkg::COUNT_BITS'(count_d);
			res_err_q    <= err_d;
			res_last_q   <= res_last;
		end
	end

	assign result_valid     = res_valid_q;
	assign status           = res_status_q;
	assign entry_index      = res_idx_q;
	assign found_payload    = res_pay_q;
	assign found_member_key = res_member_q;
	assign entries_used     = res_used_q;
	assign load_error       = res_err_q;
	assign last             = res_last_q;

	`KST_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(TABLE_DEPTH), "entry count beyond table depth")
	`KST_ASSERT_NOW(a_busy_from_request, clk, arst_n, $rose(busy), $past(start), "busy rose without a request")
	`KST_ASSERT_NEXT(a_error_sticky, clk, arst_n, err_q, err_q, "overflow flag cleared")
	`KST_ASSERT_NEXT(a_collect_continues, clk, arst_n, result_valid && !last, result_valid, "collect stopped before its end marker")

endmodule

// File: rtl/core/kst_cell.sv
// One table entry: stored key and payload, a compare, and a pending bit.
// Depends on kst_pkg; chained by keyed_setting_table through the hit line.
module kst_cell #(
	parameter int unsigned PAYLOAD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kst_pkg::cell_ctrl_t           ctrl,
	input  logic                          valid,
	input  kst_pkg::key_t                 cmp_key,
	input  logic                          wr_key,
	input  logic                          wr_pay,
	input  logic [PAYLOAD_BITS-1:0]       wr_data,
	input  logic                          hit_in,
	output logic                          hit_out,
	output logic                          first,
	output logic [kst_pkg::HASH_BITS-1:0] member,
	output logic [PAYLOAD_BITS-1:0]       payload
);

	kst_pkg::key_t           key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic                    pend_q;
	logic                    match;

	always_comb begin
		match = valid && (key_q.group == cmp_key.group) && (key_q.name == cmp_key.name)
			&& (!ctrl.full_key || (key_q.member == cmp_key.member));
	end

	// first pending cell: nothing pending on the lower side of the chain
	assign first   = pend_q && !hit_in;
	assign hit_out = pend_q || hit_in;
	assign member  = key_q.member;
	assign payload = pay_q;

	always_ff @(posedge clk) begin
		if (wr_key) begin
			key_q <= cmp_key;
		end
		if (wr_pay) begin
			pay_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (ctrl.load) begin
			pend_q <= match;
		end else if (ctrl.consume && first) begin
			pend_q <= 1'b0;
		end
	end

endmodule

// File: dv/tb_keyed_setting_table.sv
// Self-checking testbench for keyed_setting_table: directed, full-table and random requests.
// Checks each result strobe against a built-in table predictor.
// Depends on kst_pkg and the keyed_setting_table RTL only.
module tb_keyed_setting_table;
	timeunit 1ns;
	timeprecision 1ps;

	import kst_pkg::*;

	localparam int unsigned DEPTH       = 32;
	localparam int unsigned SETTLE      = 12;
	localparam int unsigned CYCLE_LIMIT = 100000;
	localparam int unsigned RANDOM_REQS = 40;
	localparam int unsigned REPLY_SLOTS = 1024;

	// kinds that the block treats as no-ops
	localparam logic [KIND_BITS-1:0] KIND_UNUSED_FIRST = 3'd5;
	localparam logic [KIND_BITS-1:0] KIND_UNUSED_LAST  = 3'd7;

	typedef struct packed {
		logic [STATUS_BITS-1:0]  status;
		logic [INDEX_BITS-1:0]   index;
		logic [OUT_PAY_BITS-1:0] payload;
		logic [HASH_BITS-1:0]    member;
		logic [COUNT_BITS-1:0]   used;
		logic                    error;
		logic                    last;
	} table_reply_t;

	logic                    clk           = 1'b0;
	logic                    arst_n        = 1'b0;
	logic                    start         = 1'b0;
	logic [KIND_BITS-1:0]    kind          = '0;
	logic [HASH_BITS-1:0]    key_group     = '0;
	logic [HASH_BITS-1:0]    key_member    = '0;
	logic [HASH_BITS-1:0]    key_name      = '0;
	logic [IN_PAY_BITS-1:0]  entry_payload = '0;
	logic                    busy;
	logic                    result_valid;
	logic [STATUS_BITS-1:0]  status;
	logic [INDEX_BITS-1:0]   entry_index;
	logic [OUT_PAY_BITS-1:0] found_payload;
	logic [HASH_BITS-1:0]    found_member_key;
	logic [COUNT_BITS-1:0]   entries_used;
	logic                    load_error;
	logic                    last;

	// table shadow
	key_t                    shadow_key [DEPTH];
	logic [OUT_PAY_BITS-1:0] shadow_payload [DEPTH];
	int unsigned             shadow_count  = 0;
	logic                    shadow_overflow = 1'b0;

	// expected results, kept in a ring with free-running head and tail counts
	table_reply_t expected_replies [REPLY_SLOTS];
	int unsigned  reply_head = 0;
	int unsigned  reply_tail = 0;

	int unsigned cycle_count     = 0;
	int unsigned mismatch_count  = 0;
	int unsigned replies_checked = 0;
	int unsigned requests_sent   = 0;
	int unsigned overflow_events = 0;
	int unsigned longest_collect = 0;
	int unsigned burst_left      = 0;

	keyed_setting_table u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.kind             (kind),
		.key_group        (key_group),
		.key_member       (key_member),
		.key_name         (key_name),
		.entry_payload    (entry_payload),
		.result_valid     (result_valid),
		.status           (status),
		.entry_index      (entry_index),
		.found_payload    (found_payload),
		.found_member_key (found_member_key),
		.entries_used     (entries_used),
		.load_error       (load_error),
		.last             (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				reply_tail - reply_head);
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic void queue_reply(input logic [STATUS_BITS-1:0] st, input int unsigned idx,
			input logic [OUT_PAY_BITS-1:0] pay, input logic [HASH_BITS-1:0] mem,
			input logic fin);
		table_reply_t r;
		r.status  = st;
		r.index   = idx[INDEX_BITS-1:0];
		r.payload = pay;
		r.member  = mem;
		r.used    = shadow_count[COUNT_BITS-1:0];
		r.error   = shadow_overflow;
		r.last    = fin;
		expected_replies[reply_tail % REPLY_SLOTS] = r;
		reply_tail++;
	endfunction

	// Update the shadow table for one request and queue the results it should produce.
	function automatic void apply_table_op(input logic [KIND_BITS-1:0] k, input key_t key,
			input logic [IN_PAY_BITS-1:0] pay);
		int hit;
		int unsigned i;
		int unsigned hit_total;
		hit = -1;
		hit_total = 0;
		case (k)
			KIND_CLEAR: begin
				shadow_count = 0;
				queue_reply(ST_DONE, 0, '0, '0, 1'b1);
			end
			KIND_POP: begin
				if (shadow_count > 0) begin
					shadow_count--;
					queue_reply(ST_DONE, shadow_count, '0, '0, 1'b1);
				end else begin
					queue_reply(ST_DONE, 0, '0, '0, 1'b1);
				end
			end
			KIND_INSERT: begin
				for (i = 0; i < shadow_count; i++)
					if (hit < 0 && shadow_key[i] == key) hit = i;
				if (hit >= 0) begin
					shadow_payload[hit] = pay;
					queue_reply(ST_REPLACED, hit, '0, '0, 1'b1);
				end else if (shadow_count < DEPTH) begin
					shadow_key[shadow_count]     = key;
					shadow_payload[shadow_count] = pay;
					shadow_count++;
					queue_reply(ST_APPENDED, shadow_count - 1, '0, '0, 1'b1);
				end else begin
					shadow_overflow = 1'b1;
					overflow_events++;
					queue_reply(ST_OVERFLOW, 0, '0, '0, 1'b1);
				end
			end
			KIND_LOOKUP: begin
				for (i = 0; i < shadow_count; i++)
					if (hit < 0 && shadow_key[i] == key) hit = i;
				if (hit >= 0) queue_reply(ST_FOUND, hit, shadow_payload[hit], '0, 1'b1);
				else queue_reply(ST_NOT_FOUND, 0, '0, '0, 1'b1);
			end
			KIND_COLLECT: begin
				for (i = 0; i < shadow_count; i++) begin
					if (shadow_key[i].group == key.group && shadow_key[i].name == key.name) begin
						queue_reply(ST_COLL_ITEM, i, '0, shadow_key[i].member, 1'b0);
						hit_total++;
					end
				end
				queue_reply(ST_COLL_END, 0, '0, '0, 1'b1);
				if (hit_total > longest_collect) longest_collect = hit_total;
			end
			default: queue_reply(ST_DONE, 0, '0, '0, 1'b1);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		table_reply_t want;
		if (arst_n && result_valid) begin
			if (reply_tail == reply_head) begin
				report_mismatch("result with nothing pending, status", 32'(status), '0);
			end else begin
				want = expected_replies[reply_head % REPLY_SLOTS];
				reply_head++;
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
				if (entry_index !== want.index)
					report_mismatch("entry_index", 32'(entry_index), 32'(want.index));
				if (found_payload !== want.payload)
					report_mismatch("found_payload", found_payload, want.payload);
				if (found_member_key !== want.member)
					report_mismatch("found_member_key", 32'(found_member_key), 32'(want.member));
				if (entries_used !== want.used)
					report_mismatch("entries_used", 32'(entries_used), 32'(want.used));
				if (load_error !== want.error)
					report_mismatch("load_error", 32'(load_error), 32'(want.error));
				if (last !== want.last) report_mismatch("last", 32'(last), 32'(want.last));
				replies_checked++;
			end
		end
	end

	// Hold start high until the block takes the request; leave it high for a following one.
	task automatic send_request(input logic [KIND_BITS-1:0] k, input key_t key,
			input logic [IN_PAY_BITS-1:0] pay);
		@(negedge clk);
		kind          = k;
		key_group     = key.group;
		key_member    = key.member;
		key_name      = key.name;
		entry_payload = pay;
		start         = 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		apply_table_op(k, key, pay);
		requests_sent++;
	endtask

	task automatic pause_sender(input int unsigned cycles);
		repeat (cycles) begin
			@(negedge clk);
			start = 1'b0;
		end
	endtask

	// Burst pacing: back-to-back requests, then a random gap.
	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			pause_sender($urandom_range(1, 6));
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 20) :
				$urandom_range(0, 4);
		end
	endtask

	task automatic wait_for_results();
		pause_sender(1);
		while (reply_tail != reply_head) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic test_directed();
		int k;
		send_request(KIND_CLEAR, '0, '0);
		send_request(KIND_POP, '0, '0);
		send_request(KIND_LOOKUP, '0, '0);
		send_request(KIND_COLLECT, '0, '0);
		send_request(KIND_INSERT, {16'h0000, 16'h0000, 16'h0000}, 32'h0000_0000);
		send_request(KIND_INSERT, {16'hFFFF, 16'hFFFF, 16'hFFFF}, 32'hFFFF_FFFF);
		send_request(KIND_INSERT, {16'h0000, 16'h0000, 16'h0000}, 32'h5A5A_A5A5);
		send_request(KIND_LOOKUP, {16'h0000, 16'h0000, 16'h0000}, '0);
		send_request(KIND_LOOKUP, {16'hFFFF, 16'hFFFF, 16'hFFFF}, '0);
		// partial key match must not count
		send_request(KIND_LOOKUP, {16'h0000, 16'h0000, 16'h0001}, '0);
		send_request(KIND_INSERT, {16'hFFFF, 16'h0000, 16'hFFFF}, 32'h8000_0001);
		send_request(KIND_COLLECT, {16'hFFFF, 16'h1234, 16'hFFFF}, '0);
		send_request(KIND_COLLECT, {16'h0000, 16'h0000, 16'hFFFF}, '0);
		for (k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
			send_request(k[KIND_BITS-1:0], {16'hFFFF, 16'hFFFF, 16'hFFFF}, 32'hFFFF_FFFF);
		send_request(KIND_POP, '0, '0);
		send_request(KIND_LOOKUP, {16'hFFFF, 16'h0000, 16'hFFFF}, '0);
		send_request(KIND_INSERT, {16'hFFFF, 16'h0000, 16'hFFFF}, 32'h0F0F_F0F0);
		send_request(KIND_CLEAR, '0, '0);
		send_request(KIND_LOOKUP, {16'h0000, 16'h0000, 16'h0000}, '0);
		send_request(KIND_POP, '0, '0);
	endtask

	task automatic test_full_table();
		logic [HASH_BITS-1:0] grp;
		logic [HASH_BITS-1:0] nam;
		logic [HASH_BITS-1:0] base;
		int unsigned i;
		grp  = HASH_BITS'($urandom_range(0, 65535));
		nam  = HASH_BITS'($urandom_range(0, 65535));
		base = HASH_BITS'($urandom_range(0, 65535));
		send_request(KIND_CLEAR, '0, '0);
		pace_sender();
		// distinct members under one group and name: collect later returns every entry
		for (i = 0; i < DEPTH; i++) begin
			send_request(KIND_INSERT, {grp, base ^ i[HASH_BITS-1:0], nam}, $urandom());
			pace_sender();
		end
		send_request(KIND_INSERT, {grp ^ 16'h0001, base, nam}, $urandom());
		pace_sender();
		// replace still works on a full table
		send_request(KIND_INSERT, {grp, base ^ 16'd7, nam}, $urandom());
		pace_sender();
		send_request(KIND_LOOKUP, {grp, base ^ 16'd7, nam}, '0);
		pace_sender();
		send_request(KIND_LOOKUP, {grp, base ^ 16'd31, nam}, '0);
		pace_sender();
		send_request(KIND_COLLECT, {grp, 16'h0000, nam}, '0);
		pace_sender();
		send_request(KIND_POP, '0, '0);
		pace_sender();
		send_request(KIND_INSERT, {~grp, ~base, ~nam}, $urandom());
		pace_sender();
		send_request(KIND_INSERT, {grp, ~base, ~nam}, $urandom());
		pace_sender();
		send_request(KIND_COLLECT, {~grp, 16'h0000, ~nam}, '0);
		pace_sender();
		send_request(KIND_CLEAR, '0, '0);
	endtask

	task automatic test_random();
		logic [HASH_BITS-1:0] group_pool [4];
		logic [HASH_BITS-1:0] member_pool [4];
		logic [HASH_BITS-1:0] name_pool [4];
		logic [KIND_BITS-1:0] k;
		key_t key;
		int unsigned n;
		int unsigned pick;
		for (n = 0; n < 4; n++) begin
			group_pool[n]  = HASH_BITS'($urandom_range(0, 65535));
			member_pool[n] = HASH_BITS'($urandom_range(0, 65535));
			name_pool[n]   = HASH_BITS'($urandom_range(0, 65535));
		end
		for (n = 0; n < RANDOM_REQS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) k = KIND_INSERT;
			else if (pick < 65) k = KIND_LOOKUP;
			else if (pick < 80) k = KIND_COLLECT;
			else if (pick < 92) k = KIND_POP;
			else if (pick < 96) k = KIND_CLEAR;
			else k = KIND_BITS'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
			// mostly pooled keys so replaces and hits happen; a few wild keys
			if ($urandom_range(0, 9) == 0) begin
				key.group  = HASH_BITS'($urandom_range(0, 65535));
				key.member = HASH_BITS'($urandom_range(0, 65535));
				key.name   = HASH_BITS'($urandom_range(0, 65535));
			end else begin
				key.group  = group_pool[$urandom_range(0, 3)];
				key.member = member_pool[$urandom_range(0, 3)];
				key.name   = name_pool[$urandom_range(0, 3)];
			end
			send_request(k, key, $urandom());
			if (n == RANDOM_REQS / 2) wait_for_results();
			else pace_sender();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		wait_for_results();
		test_full_table();
		wait_for_results();
		test_random();
		wait_for_results();
		$display("%0d requests sent, %0d results compared, %0d mismatches", requests_sent,
			replies_checked, mismatch_count);
		$display("overflows hit %0d times, longest collect returned %0d members",
			overflow_events, longest_collect);
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/kst_pkg.sv
rtl/core/kst_cell.sv
rtl/core/keyed_setting_table.sv
dv/tb_keyed_setting_table.sv
